/* rtl/ppr_pkg.sv */
// Shared types, register codes and bit positions for the parallel port register model.
package ppr_pkg;

	// Access kinds
	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// Register offsets
	localparam logic [2:0] OFS_DATA    = 3'd0;
	localparam logic [2:0] OFS_STATUS  = 3'd1;
	localparam logic [2:0] OFS_CONTROL = 3'd2;

	// Status bits: busy_n(7) ack(6) online(4) error_n(3) timeout(0)
	localparam logic [7:0] STS_BUSY   = 8'h80;
	localparam logic [7:0] STS_ACK    = 8'h40;
	localparam logic [7:0] STS_ONLINE = 8'h10;
	localparam logic [7:0] STS_ERROR  = 8'h08;
	localparam logic [7:0] STS_TMOUT  = 8'h01;
	localparam int unsigned STS_BUSY_BIT = 7;
	localparam int unsigned STS_ACK_BIT  = 6;

	// Control bits: forced(7:6) dir(5) inten(4) select(3) init_n(2) autolf(1) strobe(0)
	localparam logic [7:0] CTR_FORCED = 8'hC0;
	localparam logic [7:0] CTR_SELECT = 8'h08;
	localparam logic [7:0] CTR_INIT   = 8'h04;
	localparam int unsigned CTR_DIR_BIT    = 5;
	localparam int unsigned CTR_INTEN_BIT  = 4;
	localparam int unsigned CTR_SELECT_BIT = 3;
	localparam int unsigned CTR_INIT_BIT   = 2;
	localparam int unsigned CTR_STROBE_BIT = 0;

	localparam logic [7:0] BYTE_ONES    = 8'hFF;
	localparam logic [7:0] INPUT_DATA   = 8'hFF;
	localparam logic [7:0] DATA_RESET   = 8'hFF;
	localparam logic [7:0] STATUS_RESET = STS_BUSY | STS_ACK | STS_ONLINE | STS_ERROR | STS_TMOUT;
	localparam logic [7:0] STATUS_INIT  = STS_BUSY | STS_ACK | STS_ONLINE | STS_ERROR;
	localparam logic [7:0] CONTROL_RESET = CTR_SELECT | CTR_INIT | CTR_FORCED;

	typedef struct packed {
		logic       func;
		logic [2:0] reg_offset;
		logic [7:0] write_data;
	} ppr_req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_level;
		logic       printer_valid;
		logic [7:0] printer_byte;
	} ppr_rsp_t;

	typedef struct packed {
		logic [7:0] data_latch;
		logic [7:0] status;
		logic [7:0] control;
		logic       irq;
	} ppr_state_t;

endpackage

/* rtl/ppr_step.sv */
// Next-state and result logic for one bus access to the port registers.
module ppr_step
	import ppr_pkg::*;
(
	input  ppr_state_t cur,
	input  ppr_req_t   req,
	output ppr_state_t nxt,
	output ppr_rsp_t   rsp
);

	logic [7:0] ctl_wr;

	assign ctl_wr = req.write_data | CTR_FORCED;

	always_comb begin
		nxt = cur;
		rsp.read_data = BYTE_ONES;
		rsp.printer_valid = 1'b0;
		rsp.printer_byte = 8'h00;
		if (req.func == FUNC_WRITE) begin
			case (req.reg_offset)
				OFS_DATA: begin
					nxt.data_latch = req.write_data;
				end
				OFS_CONTROL: begin
					if (!ctl_wr[CTR_INIT_BIT]) begin
						nxt.status = STATUS_INIT;
					end else if (ctl_wr[CTR_SELECT_BIT]) begin
						if (ctl_wr[CTR_STROBE_BIT]) begin
							nxt.status[STS_BUSY_BIT] = 1'b0;
							// rising strobe sends the latch out
							if (!cur.control[CTR_STROBE_BIT]) begin
								rsp.printer_valid = 1'b1;
								rsp.printer_byte = cur.data_latch;
							end
						end else if (cur.control[CTR_INTEN_BIT]) begin
							nxt.irq = 1'b1;
						end
					end
					nxt.control = ctl_wr;
				end
				default: begin
				end
			endcase
		end else begin
			case (req.reg_offset)
				OFS_DATA: begin
					rsp.read_data = cur.control[CTR_DIR_BIT] ? INPUT_DATA : cur.data_latch;
				end
				OFS_STATUS: begin
					rsp.read_data = cur.status;
					nxt.irq = 1'b0;
					// step the ack/busy handshake while busy (busy_n low) with strobe low
					if (!cur.status[STS_BUSY_BIT] && !cur.control[CTR_STROBE_BIT]) begin
						if (cur.status[STS_ACK_BIT])
							nxt.status[STS_ACK_BIT] = 1'b0;
						else
							nxt.status = cur.status | STS_ACK | STS_BUSY;
					end
				end
				OFS_CONTROL: begin
					rsp.read_data = cur.control;
				end
				default: begin
				end
			endcase
		end
		rsp.irq_level = nxt.irq;
	end

endmodule

/* rtl/parallel_port_register_model_unit.sv */
// Top level of the parallel port register model: register state and response register.
//
// Channel  | Signals                        | Direction | Content
// ---------+--------------------------------+-----------+-------------------------------
// request  | req_valid, req_ready, req      | in        | func, reg_offset, write_data
// response | rsp_valid, rsp_ready, rsp      | out       | read_data, irq_level, printer
//
// The register state updates at the request transfer and the result lands in the
// response register on the same edge. One access per cycle is sustained while
// rsp_ready is high; the single response register sets that figure.
// A request is taken whenever the response register is empty or being drained.
// A stalled response holds the request side off; nothing else stalls.
// Reset loads the power-on register values and empties the response register.
module parallel_port_register_model_unit
	import ppr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ppr_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ppr_rsp_t rsp
);

	ppr_state_t state_q;
	ppr_state_t state_nxt;
	ppr_rsp_t   rsp_nxt;
	ppr_rsp_t   rsp_q;
	logic       rsp_valid_q;
	logic       req_xfer;

	// Take a request when the response slot is free or drains this cycle.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign req_xfer  = req_valid && req_ready;

	ppr_step u_step (
		.cur (state_q),
		.req (req),
		.nxt (state_nxt),
		.rsp (rsp_nxt)
	);

	// Register file: advance only on a request transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.data_latch <= DATA_RESET;
			state_q.status <= STATUS_RESET;
			state_q.control <= CONTROL_RESET;
			state_q.irq <= 1'b0;
		end else if (req_xfer) begin
			state_q <= state_nxt;
		end
	end

	// Response valid: set on a request transfer, drop when taken without refill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_xfer) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload: load on transfer, hold otherwise.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |-> !req_ready)
		else $error("request taken while response stalled");

	a_ctl_forced: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.control[7:6] == 2'b11)
		else $error("control bits 7:6 not forced high");

	a_status_read_clears_irq: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req.func == FUNC_READ && req.reg_offset == OFS_STATUS
		|=> !state_q.irq && !rsp_q.irq_level)
		else $error("status read left interrupt pending");

	a_irq_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> rsp_q.irq_level == state_q.irq)
		else $error("irq level differs from pending flag");

	a_printer_byte_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.printer_valid |-> rsp_q.printer_byte == 8'h00)
		else $error("printer byte set without printer transfer");
`endif

endmodule
